[rtl/mqd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqd_pkg: shared types and codes for the MQTT packet deframer
// Parser phases, byte role codes, verdict codes and packet type codes.
// ----------------------------------------------------------------------------
package mqd_pkg;

  localparam int MAX_LENGTH_BYTES_DEF = 4;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_LENGTH = 2'd1,
    PH_BODY   = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ROLE_HEADER    = 3'd0,
    ROLE_LENGTH    = 3'd1,
    ROLE_TOPIC_LEN = 3'd2,
    ROLE_TOPIC     = 3'd3,
    ROLE_PACKET_ID = 3'd4,
    ROLE_PAYLOAD   = 3'd5,
    ROLE_OTHER     = 3'd6
  } role_t;

  typedef enum logic [2:0] {
    VERDICT_NONE        = 3'd0,
    VERDICT_CONNACK_OK  = 3'd1,
    VERDICT_CONNACK_REF = 3'd2,
    VERDICT_PUBLISH_OK  = 3'd3,
    VERDICT_PUBLISH_DROP = 3'd4,
    VERDICT_PINGRESP    = 3'd5,
    VERDICT_OTHER       = 3'd6
  } verdict_t;

  localparam logic [3:0] KIND_CONNACK  = 4'd2;
  localparam logic [3:0] KIND_PUBLISH  = 4'd3;
  localparam logic [3:0] KIND_PINGRESP = 4'd13;

  localparam logic [1:0] QOS_0 = 2'd0;
  localparam logic [1:0] QOS_1 = 2'd1;
  localparam logic [1:0] QOS_2 = 2'd2;
  localparam logic [1:0] QOS_3 = 2'd3;

  localparam int LEN_DIGIT_W = 7;

endpackage

[rtl/mqd_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqd_byte_if / mqd_result_if: valid/ready channels of the deframer
// Input channel carries one received byte; result channel one tagged byte.
// ----------------------------------------------------------------------------
interface mqd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface mqd_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [2:0]  byte_role;
  logic        packet_end;
  logic [3:0]  packet_kind;
  logic [1:0]  qos_level;
  logic [15:0] message_id;
  logic [2:0]  verdict;
  logic        send_ack;
  logic        length_error;

  modport source (
    output valid, output out_byte, output byte_role, output packet_end,
    output packet_kind, output qos_level, output message_id, output verdict,
    output send_ack, output length_error, input ready
  );
  modport sink (
    input valid, input out_byte, input byte_role, input packet_end,
    input packet_kind, input qos_level, input message_id, input verdict,
    input send_ack, input length_error, output ready
  );
endinterface

[rtl/mqtt_packet_deframer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqtt_packet_deframer_top: MQTT fixed header parser and byte tagger
// Each accepted byte beat is registered and shows up as its result beat in the next cycle.
// Throughput: one byte per cycle; the parser state and the result register
//   update in the same cycle, so the only stall is a full result register.
// Reset (rst, synchronous): parser waits for a header byte, all captured
//   fields are cleared and the result register is empty.
// ----------------------------------------------------------------------------
module mqtt_packet_deframer_top #(
  parameter int MAX_LENGTH_BYTES = mqd_pkg::MAX_LENGTH_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  mqd_byte_if.sink             byte_ch,
  mqd_result_if.source         result_ch
);

  localparam int LEN_W  = mqd_pkg::LEN_DIGIT_W * MAX_LENGTH_BYTES;
  localparam int SEEN_W = $clog2(MAX_LENGTH_BYTES + 1);
  localparam int CMP_W  = ((LEN_W > 17) ? LEN_W : 17) + 1;

  // parser state
  mqd_pkg::phase_t    phase, phase_next;
  logic [7:0]         header_reg, header_next;
  logic [LEN_W-1:0]   length_accum, accum_next;
  logic [SEEN_W-1:0]  length_bytes_seen, seen_next;
  logic [LEN_W-1:0]   body_position, pos_next;
  logic [15:0]        topic_len, topic_next;
  logic [15:0]        id_reg, id_next;
  logic               second_byte_zero, sbz_next;

  // per-beat decode
  logic [7:0]         b;
  logic               accept;
  logic               len_overflow;
  logic               len_last;
  logic               body_last;
  logic [CMP_W-1:0]   pos_ext;
  logic [CMP_W-1:0]   topic_ext;
  logic [CMP_W-1:0]   pos_inc;
  logic               has_id;
  logic [1:0]         qos_cur;
  logic [3:0]         kind_cur;

  mqd_pkg::role_t     role;
  mqd_pkg::verdict_t  verd;
  logic               pkt_end;
  logic               err;

  assign b       = byte_ch.in_byte;
  assign byte_ch.ready = !result_ch.valid || result_ch.ready;
  assign accept  = byte_ch.valid && byte_ch.ready;

  assign kind_cur = header_reg[7:4];
  assign qos_cur  = header_reg[2:1];
  assign has_id   = (qos_cur == mqd_pkg::QOS_1) || (qos_cur == mqd_pkg::QOS_2);

  assign len_overflow = length_bytes_seen >= SEEN_W'(MAX_LENGTH_BYTES);
  assign len_last     = !b[7];
  assign pos_ext      = CMP_W'(body_position);
  assign topic_ext    = CMP_W'(topic_len);
  assign pos_inc      = pos_ext + CMP_W'(1);
  assign body_last    = pos_inc >= CMP_W'(length_accum);

  // structural verdict on the final byte of a packet
  function automatic mqd_pkg::verdict_t judge(
    input logic [3:0]       kind,
    input logic [1:0]       qos,
    input logic [LEN_W-1:0] len,
    input logic [15:0]      tlen,
    input logic             sbz
  );
    logic [CMP_W-1:0] len_x;
    logic [CMP_W-1:0] tlen_x;
    mqd_pkg::verdict_t v;
    len_x  = CMP_W'(len);
    tlen_x = CMP_W'(tlen);
    if (kind == mqd_pkg::KIND_CONNACK) begin
      v = (len_x == CMP_W'(2) && sbz) ? mqd_pkg::VERDICT_CONNACK_OK
                                      : mqd_pkg::VERDICT_CONNACK_REF;
    end else if (kind == mqd_pkg::KIND_PINGRESP) begin
      v = mqd_pkg::VERDICT_PINGRESP;
    end else if (kind != mqd_pkg::KIND_PUBLISH) begin
      v = mqd_pkg::VERDICT_OTHER;
    end else if (len_x < CMP_W'(2) || qos == mqd_pkg::QOS_3 || tlen == 16'd0 ||
                 tlen_x > len_x - CMP_W'(2)) begin
      v = mqd_pkg::VERDICT_PUBLISH_DROP;
    end else if (qos != mqd_pkg::QOS_0 && tlen_x + CMP_W'(4) > len_x) begin
      v = mqd_pkg::VERDICT_PUBLISH_DROP;
    end else begin
      v = mqd_pkg::VERDICT_PUBLISH_OK;
    end
    return v;
  endfunction

  // next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      mqd_pkg::PH_HEADER: phase_next = mqd_pkg::PH_LENGTH;
      mqd_pkg::PH_LENGTH: begin
        if (len_overflow) begin
          phase_next = mqd_pkg::PH_HEADER;
        end else if (len_last) begin
          phase_next = (accum_next == '0) ? mqd_pkg::PH_HEADER : mqd_pkg::PH_BODY;
        end
      end
      mqd_pkg::PH_BODY: begin
        if (body_last) phase_next = mqd_pkg::PH_HEADER;
      end
      default: phase_next = mqd_pkg::PH_HEADER;
    endcase
  end

  // datapath and result fields
  always_comb begin
    header_next = header_reg;
    accum_next  = length_accum;
    seen_next   = length_bytes_seen;
    pos_next    = body_position;
    topic_next  = topic_len;
    id_next     = id_reg;
    sbz_next    = second_byte_zero;
    role        = mqd_pkg::ROLE_HEADER;
    verd        = mqd_pkg::VERDICT_NONE;
    pkt_end     = 1'b0;
    err         = 1'b0;
    case (phase)
      mqd_pkg::PH_HEADER: begin
        header_next = b;
        accum_next  = '0;
        seen_next   = '0;
        pos_next    = '0;
        topic_next  = '0;
        id_next     = '0;
        sbz_next    = 1'b0;
      end
      mqd_pkg::PH_LENGTH: begin
        role = mqd_pkg::ROLE_LENGTH;
        if (len_overflow) begin
          err = 1'b1;
        end else begin
          for (int i = 0; i < MAX_LENGTH_BYTES; i++) begin
            if (length_bytes_seen == SEEN_W'(i)) begin
              accum_next[i*mqd_pkg::LEN_DIGIT_W +: mqd_pkg::LEN_DIGIT_W] =
                length_accum[i*mqd_pkg::LEN_DIGIT_W +: mqd_pkg::LEN_DIGIT_W] | b[6:0];
            end
          end
          seen_next = length_bytes_seen + SEEN_W'(1);
          if (len_last) begin
            pos_next = '0;
            if (accum_next == '0) begin
              pkt_end = 1'b1;
              verd    = judge(kind_cur, qos_cur, '0, topic_len, second_byte_zero);
            end
          end
        end
      end
      mqd_pkg::PH_BODY: begin
        if (body_position == LEN_W'(1) && b == 8'd0) sbz_next = 1'b1;
        if (kind_cur == mqd_pkg::KIND_PUBLISH) begin
          if (body_position == '0) begin
            topic_next = {b, 8'd0};
            role       = mqd_pkg::ROLE_TOPIC_LEN;
          end else if (body_position == LEN_W'(1)) begin
            topic_next = {topic_len[15:8], b};
            role       = mqd_pkg::ROLE_TOPIC_LEN;
          end else if (pos_ext < topic_ext + CMP_W'(2)) begin
            role = mqd_pkg::ROLE_TOPIC;
          end else if (has_id && pos_ext == topic_ext + CMP_W'(2)) begin
            id_next = {b, 8'd0};
            role    = mqd_pkg::ROLE_PACKET_ID;
          end else if (has_id && pos_ext == topic_ext + CMP_W'(3)) begin
            id_next = {id_reg[15:8], b};
            role    = mqd_pkg::ROLE_PACKET_ID;
          end else begin
            role = mqd_pkg::ROLE_PAYLOAD;
          end
        end else begin
          role = mqd_pkg::ROLE_OTHER;
        end
        pos_next = pos_inc[LEN_W-1:0];
        if (body_last) begin
          pkt_end = 1'b1;
          verd    = judge(kind_cur, qos_cur, length_accum, topic_next, sbz_next);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= mqd_pkg::PH_HEADER;
      header_reg        <= '0;
      length_accum      <= '0;
      length_bytes_seen <= '0;
      body_position     <= '0;
      topic_len         <= '0;
      id_reg            <= '0;
      second_byte_zero  <= 1'b0;
    end else if (accept) begin
      phase             <= phase_next;
      header_reg        <= header_next;
      length_accum      <= accum_next;
      length_bytes_seen <= seen_next;
      body_position     <= pos_next;
      topic_len         <= topic_next;
      id_reg            <= id_next;
      second_byte_zero  <= sbz_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_ch.valid <= 1'b0;
    end else if (accept) begin
      result_ch.valid <= 1'b1;
    end else if (result_ch.ready) begin
      result_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_ch.out_byte     <= b;
      result_ch.byte_role    <= role;
      result_ch.packet_end   <= pkt_end;
      result_ch.packet_kind  <= header_next[7:4];
      result_ch.qos_level    <= header_next[2:1];
      result_ch.message_id   <= id_next;
      result_ch.verdict      <= verd;
      result_ch.send_ack     <= pkt_end && (verd == mqd_pkg::VERDICT_PUBLISH_OK) &&
                                (header_next[2:1] == mqd_pkg::QOS_1);
      result_ch.length_error <= err;
    end
  end

endmodule

[tb/mqd_deframer_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqd_deframer_check: result checker for the MQTT packet deframer
// Watches both channels. Each accepted byte beat runs through a deframer
// model that queues the tagged result it should produce. Each result beat is
// compared with the oldest queued one. Mismatches are counted for the top.
// ----------------------------------------------------------------------------
module mqd_deframer_check
  import mqd_pkg::*;
#(
  parameter int MAX_LEN_BYTES = mqd_pkg::MAX_LENGTH_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  mqd_byte_if         byte_ch,
  mqd_result_if       result_ch,
  output int unsigned fail_count,
  output int unsigned pending
);

  typedef struct packed {
    logic [7:0]  out_byte;
    role_t       role;
    logic        packet_end;
    logic [3:0]  kind;
    logic [1:0]  qos;
    logic [15:0] msg_id;
    verdict_t    verdict;
    logic        send_ack;
    logic        length_error;
  } byte_tag_t;

  byte_tag_t tag_q[$];

  // deframer state
  phase_t      ph;
  logic [7:0]  hdr;
  logic [27:0] len_acc;
  logic [2:0]  len_cnt;
  logic [27:0] body_pos;
  logic [15:0] topic_len;
  logic [15:0] pkt_id;
  logic        second_zero;

  function automatic void clear_fields();
    len_acc     = '0;
    len_cnt     = '0;
    body_pos    = '0;
    topic_len   = '0;
    pkt_id      = '0;
    second_zero = 1'b0;
  endfunction

  function automatic verdict_t packet_verdict(input logic [27:0] len);
    int unsigned lu;
    int unsigned tu;
    lu = len;
    tu = topic_len;
    if (hdr[7:4] == KIND_CONNACK)
      return (lu == 2 && second_zero) ? VERDICT_CONNACK_OK : VERDICT_CONNACK_REF;
    if (hdr[7:4] == KIND_PINGRESP) return VERDICT_PINGRESP;
    if (hdr[7:4] != KIND_PUBLISH) return VERDICT_OTHER;
    if (lu < 2 || hdr[2:1] == QOS_3 || tu == 0 || tu > lu - 2) return VERDICT_PUBLISH_DROP;
    // QoS 1/2 needs both id bytes inside the body
    if (hdr[2:1] != QOS_0 && tu + 4 > lu) return VERDICT_PUBLISH_DROP;
    return VERDICT_PUBLISH_OK;
  endfunction

  function automatic byte_tag_t deframe_step(input logic [7:0] b);
    byte_tag_t   r;
    int unsigned p;
    int unsigned tl;
    logic        has_id;
    r = '0;
    r.out_byte = b;
    r.role     = ROLE_HEADER;
    r.verdict  = VERDICT_NONE;
    case (ph)
      PH_HEADER: begin
        hdr = b;
        clear_fields();
        ph = PH_LENGTH;
      end
      PH_LENGTH: begin
        r.role = ROLE_LENGTH;
        if (len_cnt >= 3'(MAX_LEN_BYTES)) begin
          r.length_error = 1'b1;
          ph = PH_HEADER;
        end else begin
          len_acc = len_acc | (28'(b[6:0]) << (LEN_DIGIT_W * len_cnt));
          len_cnt = len_cnt + 3'd1;
          if (!b[7]) begin
            if (len_acc == '0) begin
              r.packet_end = 1'b1;
              r.verdict    = packet_verdict('0);
              ph = PH_HEADER;
            end else begin
              body_pos = '0;
              ph = PH_BODY;
            end
          end
        end
      end
      default: begin
        p      = body_pos;
        tl     = topic_len;
        has_id = (hdr[2:1] == QOS_1 || hdr[2:1] == QOS_2);
        if (p == 1 && b == 8'h00) second_zero = 1'b1;
        if (hdr[7:4] == KIND_PUBLISH) begin
          if (p == 0) begin
            topic_len = {b, 8'h00};
            r.role = ROLE_TOPIC_LEN;
          end else if (p == 1) begin
            topic_len = topic_len | {8'h00, b};
            r.role = ROLE_TOPIC_LEN;
          end else if (p < 2 + tl) begin
            r.role = ROLE_TOPIC;
          end else if (has_id && p == 2 + tl) begin
            pkt_id = {b, 8'h00};
            r.role = ROLE_PACKET_ID;
          end else if (has_id && p == 3 + tl) begin
            pkt_id = pkt_id | {8'h00, b};
            r.role = ROLE_PACKET_ID;
          end else begin
            r.role = ROLE_PAYLOAD;
          end
        end else begin
          r.role = ROLE_OTHER;
        end
        body_pos = 28'(p + 1);
        if (p + 1 >= int'(len_acc)) begin
          r.packet_end = 1'b1;
          r.verdict    = packet_verdict(len_acc);
          ph = PH_HEADER;
        end
      end
    endcase
    r.kind     = hdr[7:4];
    r.qos      = hdr[2:1];
    r.msg_id   = pkt_id;
    r.send_ack = r.packet_end && r.verdict == VERDICT_PUBLISH_OK && hdr[2:1] == QOS_1;
    return r;
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin : watch
    byte_tag_t got;
    byte_tag_t want;
    if (rst) begin
      ph  = PH_HEADER;
      hdr = '0;
      clear_fields();
      tag_q.delete();
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        got.out_byte     = result_ch.out_byte;
        got.role         = role_t'(result_ch.byte_role);
        got.packet_end   = result_ch.packet_end;
        got.kind         = result_ch.packet_kind;
        got.qos          = result_ch.qos_level;
        got.msg_id       = result_ch.message_id;
        got.verdict      = verdict_t'(result_ch.verdict);
        got.send_ack     = result_ch.send_ack;
        got.length_error = result_ch.length_error;
        if (tag_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result beat with nothing outstanding, byte %h", $realtime,
                     got.out_byte);
          fail_count++;
        end else begin
          want = tag_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10) begin
              $display("%0t: mismatch byte/role/end/kind/qos/id/verdict/ack/err", $realtime);
              $display("  exp %h %0d %b %h %0d %h %0d %b %b", want.out_byte, want.role,
                       want.packet_end, want.kind, want.qos, want.msg_id, want.verdict,
                       want.send_ack, want.length_error);
              $display("  got %h %0d %b %h %0d %h %0d %b %b", got.out_byte, got.role,
                       got.packet_end, got.kind, got.qos, got.msg_id, got.verdict,
                       got.send_ack, got.length_error);
            end
            fail_count++;
          end
        end
      end
      if (byte_ch.valid && byte_ch.ready)
        tag_q.push_back(deframe_step(byte_ch.in_byte));
    end
    pending = tag_q.size();
  end

endmodule

[tb/mqtt_packet_deframer_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqtt_packet_deframer_top_test: stream test of the MQTT packet deframer
// Sends a short directed set of packets, then random packet streams (mostly
// well-formed, some truncated, overlong or noise) with random gaps and
// receiver stalls, including one long hold-off. The checker does the rest.
// ----------------------------------------------------------------------------
module mqtt_packet_deframer_top_test;
  import mqd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 5_000_000;
  localparam int unsigned RANDOM_BEATS = 1100;
  localparam int unsigned LONG_HOLD    = 400;

  typedef logic [7:0] byte_q_t[$];

  logic        clk;
  logic        rst;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned beats_sent;
  int unsigned cycle_cnt;
  bit          tx_quiet;
  bit          long_hold_done;

  mqd_byte_if   byte_ch();
  mqd_result_if result_ch();

  mqtt_packet_deframer_top DUT (
    .clk       (clk),
    .rst       (rst),
    .byte_ch   (byte_ch),
    .result_ch (result_ch)
  );

  mqd_deframer_check frame_check (
    .clk        (clk),
    .rst        (rst),
    .byte_ch    (byte_ch),
    .result_ch  (result_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_beat(input logic [7:0] b);
    byte_ch.valid   <= 1'b1;
    byte_ch.in_byte <= b;
    do @(posedge clk); while (!byte_ch.ready);
    beats_sent++;
    if (!tx_quiet && $urandom_range(0, 3) == 0) begin
      byte_ch.valid   <= 1'b0;
      byte_ch.in_byte <= 8'($urandom());
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  task automatic send_stream(input byte_q_t q);
    foreach (q[i]) send_beat(q[i]);
  endtask

  // 7-bit little-endian length, padded with zero digits up to width bytes
  function automatic byte_q_t length_field(input int unsigned len, input int unsigned width);
    byte_q_t     q;
    int unsigned v;
    v = len;
    do begin
      q.push_back(8'(v & 32'h7f));
      v = v >> 7;
    end while (v != 0);
    while (q.size() < width) q.push_back(8'h00);
    for (int i = 0; i < q.size() - 1; i++) q[i][7] = 1'b1;
    return q;
  endfunction

  task automatic send_packet(input logic [7:0] hdr, input byte_q_t body,
                             input int unsigned width);
    byte_q_t q;
    q = {hdr};
    q = {q, length_field(body.size(), width)};
    q = {q, body};
    send_stream(q);
  endtask

  function automatic byte_q_t random_bytes(input int unsigned n);
    byte_q_t q;
    repeat (n) q.push_back(8'($urandom()));
    return q;
  endfunction

  function automatic byte_q_t publish_body(input logic [1:0] qos, input int unsigned tl,
                                           input int unsigned pl);
    byte_q_t q;
    q = {8'(tl >> 8), 8'(tl)};
    q = {q, random_bytes(tl)};
    if (qos == QOS_1 || qos == QOS_2) q = {q, random_bytes(2)};
    q = {q, random_bytes(pl)};
    return q;
  endfunction

  function automatic logic [7:0] header_of(input logic [3:0] kind);
    return {kind, 4'($urandom())};
  endfunction

  function automatic int unsigned pick_width();
    return ($urandom_range(0, 4) == 0) ? $urandom_range(2, 4) : 1;
  endfunction

  task automatic send_random_packet();
    byte_q_t     body;
    logic [1:0]  qos;
    int unsigned pick;
    int unsigned cut;
    pick = $urandom_range(0, 99);
    qos  = 2'($urandom());
    tx_quiet = ($urandom_range(0, 3) == 0);
    if (pick < 40) begin
      // publish with matching lengths (any QoS, topic length 0 to 9), occasionally a long payload for 2-byte lengths
      body = publish_body(qos, $urandom_range(0, 9),
                          ($urandom_range(0, 29) == 0) ? $urandom_range(120, 260)
                                                       : $urandom_range(0, 10));
      send_packet({KIND_PUBLISH, 1'($urandom()), qos, 1'($urandom())}, body, pick_width());
    end else if (pick < 52) begin
      // truncated or lying publish
      body = publish_body(qos, $urandom_range(0, 6), $urandom_range(0, 3));
      if ($urandom_range(0, 2) == 0) body[0] = 8'($urandom());
      cut = $urandom_range(0, body.size() - 1);
      repeat (cut) void'(body.pop_back());
      send_packet({KIND_PUBLISH, 1'($urandom()), qos, 1'($urandom())}, body, pick_width());
    end else if (pick < 62) begin
      body = random_bytes(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : 2);
      if ($urandom_range(0, 1) == 0 && body.size() > 1) body[1] = 8'h00;
      send_packet(header_of(KIND_CONNACK), body, pick_width());
    end else if (pick < 70) begin
      body = random_bytes(($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
      send_packet(header_of(KIND_PINGRESP), body, pick_width());
    end else if (pick < 80) begin
      body = random_bytes($urandom_range(0, 8));
      send_packet(header_of(4'($urandom())), body, pick_width());
    end else if (pick < 88) begin
      // more than the allowed continued length bytes
      body = {8'($urandom())};
      repeat (mqd_pkg::MAX_LENGTH_BYTES_DEF) body.push_back(8'($urandom()) | 8'h80);
      body.push_back(8'($urandom()));
      send_stream(body);
    end else begin
      // noise: any header, short body of arbitrary bytes
      send_packet(8'($urandom()), random_bytes($urandom_range(0, 6)), pick_width());
    end
  endtask

  // receiver: random stalls, calm stretches, and one long hold-off
  initial begin : receiver
    int unsigned stall_left;
    int unsigned calm_left;
    stall_left = 0;
    calm_left  = 0;
    long_hold_done = 1'b0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && !long_hold_done && beats_sent >= 300) begin
        long_hold_done = 1'b1;
        result_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
      end else if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
        if (calm_left > 0) calm_left--;
        else if ($urandom_range(0, 59) == 0) calm_left = $urandom_range(100, 300);
        else if ($urandom_range(0, 5) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin : stimulus
    byte_q_t big;
    rst             = 1'b1;
    byte_ch.valid   = 1'b0;
    byte_ch.in_byte = 8'h00;
    beats_sent      = 0;
    cycle_cnt       = 0;
    tx_quiet        = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // pingresp, connack accepted, zero-length connack and publish
    send_stream({8'hD0, 8'h00});
    send_stream({8'h20, 8'h02, 8'h00, 8'h00});
    send_stream({8'h20, 8'h00});
    send_stream({8'h30, 8'h00});
    // fifth length byte
    send_stream({8'h30, 8'h80, 8'h80, 8'h80, 8'h80, 8'h7F});
    // QoS 1 publish, kept, asks for an ack
    send_stream({8'h32, 8'h06, 8'h00, 8'h01, 8'h61, 8'h12, 8'h34, 8'hFF});
    // QoS 3 publish with a padded four-byte length
    send_stream({8'h36, 8'h85, 8'h80, 8'h80, 8'h00, 8'h00, 8'h01, 8'h41, 8'h42, 8'h43});

    while (beats_sent < RANDOM_BEATS) send_random_packet();

    // one long body: two-byte length and a topic length above 255
    tx_quiet = 1'b1;
    big = publish_body(QOS_2, 300, 60);
    send_packet({KIND_PUBLISH, 1'b0, QOS_2, 1'b1}, big, 1);
    tx_quiet = 1'b0;
    send_random_packet();

    byte_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/mqd_pkg.sv
rtl/mqd_if.sv
rtl/mqtt_packet_deframer_top.sv
tb/mqd_deframer_check.sv
tb/mqtt_packet_deframer_top_test.sv
